FILE: rtl/tty_output_converter_defines.svh
// Assertion macros used by the converter's back stage (tto_back).
`ifndef TTY_OUTPUT_CONVERTER_DEFINES_SVH
`define TTY_OUTPUT_CONVERTER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TTO_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define TTO_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tto_pkg.sv
`timescale 1ns / 1ps

package tto_pkg;

    localparam int TAB_STOP = 8;
    localparam int GAP_W    = $clog2(TAB_STOP + 1);

    // configuration register indexes
    localparam logic [2:0] REG_RAW_MODE   = 3'd0;
    localparam logic [2:0] REG_CR_MODE    = 3'd1;
    localparam logic [2:0] REG_NL_DELAY   = 3'd2;
    localparam logic [2:0] REG_TAB_DELAY  = 3'd3;
    localparam logic [2:0] REG_CR_DELAY   = 3'd4;
    localparam logic [2:0] REG_VERT_DELAY = 3'd5;

    // character codes
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_DEL   = 8'd127;

    // delay styles and lengths
    localparam logic [1:0] NL_COLUMN   = 2'd1;
    localparam logic [1:0] NL_FIXED    = 2'd2;
    localparam logic [1:0] TAB_COLUMN  = 2'd1;
    localparam logic [1:0] TAB_EXPAND  = 2'd3;
    localparam logic [1:0] CRD_SHORT   = 2'd1;
    localparam logic [1:0] CRD_MEDIUM  = 2'd2;
    localparam logic [1:0] CRD_LONG    = 2'd3;
    localparam logic [6:0] DLY_NONE    = 7'd0;
    localparam logic [6:0] DLY_NL_MIN  = 7'd6;
    localparam logic [4:0] DLY_NL_ADD  = 5'd3;
    localparam logic [6:0] DLY_TAB_MIN = 7'd5;
    localparam logic [6:0] DLY_CR_S    = 7'd5;
    localparam logic [6:0] DLY_CR_M    = 7'd10;
    localparam logic [6:0] DLY_CR_L    = 7'd20;
    localparam logic [6:0] DLY_VERT    = 7'd127;

    // result slots walked by the output sequencer
    typedef enum logic [1:0] {
        SL_C0,
        SL_D0,
        SL_C1,
        SL_D1
    } t_slot;

    typedef struct packed {
        logic       raw_mode;
        logic       cr_mode;
        logic [1:0] nl_delay;
        logic [1:0] tab_delay;
        logic [1:0] cr_delay;
        logic       vert_delay;
    } t_cfg;

    // Result list for one item: first character (repeated cnt times), its delay,
    // an optional line feed and its delay. A zero delay means no delay result.
    typedef struct packed {
        logic [7:0]       c0;
        logic [GAP_W-1:0] cnt;
        logic [6:0]       d0;
        logic             c1_en;
        logic [6:0]       d1;
    } t_plan;

    // distance to the next tab stop for every column value
    typedef logic [GAP_W-1:0] t_gap_tbl [256];

    function automatic t_gap_tbl build_gap_tbl();
        t_gap_tbl tbl;
        for (int i = 0; i < 256; i++) begin
            tbl[i] = GAP_W'(TAB_STOP - (i % TAB_STOP));
        end
        return tbl;
    endfunction

    localparam t_gap_tbl GAP_TBL = build_gap_tbl();

endpackage

FILE: rtl/tto_front.sv
`timescale 1ns / 1ps

module tto_front
    import tto_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_in,
    output logic       o_plan_vld,
    output t_plan      o_plan,
    input  logic       i_take
);

    logic [7:0]       r_column;
    logic [7:0]       n_column;
    logic             r_plan_vld;
    t_plan            r_plan;
    t_plan            n_plan;
    logic [7:0]       c7;
    logic [GAP_W-1:0] gap;
    logic [GAP_W:0]   tab_d;
    logic [4:0]       nl_base;
    logic             accept;

    assign o_stall = r_plan_vld && !i_take;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        c7      = {1'b0, i_char_in[6:0]};
        gap     = GAP_TBL[r_column];
        tab_d   = (GAP_W + 1)'(gap) + (GAP_W + 1)'(1);
        nl_base = 5'(r_column[7:4]) + DLY_NL_ADD;

        n_plan.c0    = c7;
        n_plan.cnt   = GAP_W'(1);
        n_plan.d0    = DLY_NONE;
        n_plan.c1_en = 1'b0;
        n_plan.d1    = DLY_NONE;
        n_column     = r_column;

        if (i_cfg.raw_mode) begin
            n_plan.c0 = i_char_in;
        end else if (c7 == CH_TAB && i_cfg.tab_delay == TAB_EXPAND) begin
            n_plan.c0 = CH_SPACE;
            n_plan.cnt = gap;
            n_column  = r_column + 8'(gap);
        end else if (c7 == CH_LF && i_cfg.cr_mode) begin
            // CR with its delay, then LF seen at column zero
            n_plan.c0    = CH_CR;
            n_plan.c1_en = 1'b1;
            case (i_cfg.cr_delay)
                CRD_SHORT:  n_plan.d0 = DLY_CR_S;
                CRD_MEDIUM: n_plan.d0 = DLY_CR_M;
                CRD_LONG:   n_plan.d0 = DLY_CR_L;
                default:    n_plan.d0 = DLY_NONE;
            endcase
            if (i_cfg.nl_delay == NL_FIXED) begin
                n_plan.d1 = DLY_NL_MIN;
            end
            n_column = 8'd0;
        end else begin
            case (c7) inside
                CH_BS: begin
                    if (r_column != 8'd0) begin
                        n_column = r_column - 8'd1;
                    end
                end
                CH_LF: begin
                    if (i_cfg.nl_delay == NL_COLUMN) begin
                        if (r_column != 8'd0) begin
                            n_plan.d0 = (7'(nl_base) < DLY_NL_MIN) ? DLY_NL_MIN
                                                                   : 7'(nl_base);
                        end
                    end else if (i_cfg.nl_delay == NL_FIXED) begin
                        n_plan.d0 = DLY_NL_MIN;
                    end
                    n_column = 8'd0;
                end
                CH_TAB: begin
                    if (i_cfg.tab_delay == TAB_COLUMN && 7'(tab_d) >= DLY_TAB_MIN) begin
                        n_plan.d0 = 7'(tab_d);
                    end
                    n_column = r_column + 8'(gap);
                end
                CH_VT, CH_FF: begin
                    if (i_cfg.vert_delay) begin
                        n_plan.d0 = DLY_VERT;
                    end
                end
                CH_CR: begin
                    case (i_cfg.cr_delay)
                        CRD_SHORT:  n_plan.d0 = DLY_CR_S;
                        CRD_MEDIUM: n_plan.d0 = DLY_CR_M;
                        CRD_LONG:   n_plan.d0 = DLY_CR_L;
                        default:    n_plan.d0 = DLY_NONE;
                    endcase
                    n_column = 8'd0;
                end
                default: begin
                    // ordinary characters advance; control codes and DEL do not
                    if (c7 >= CH_SPACE && c7 != CH_DEL) begin
                        n_column = r_column + 8'd1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column   <= 8'd0;
            r_plan_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_column   <= n_column;
                r_plan_vld <= 1'b1;
            end else if (i_take) begin
                r_plan_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_plan <= n_plan;
        end
    end

    assign o_plan_vld = r_plan_vld;
    assign o_plan     = r_plan;

endmodule

FILE: rtl/tto_back.sv
`timescale 1ns / 1ps
`include "tty_output_converter_defines.svh"

module tto_back
    import tto_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_plan_vld,
    input  t_plan      i_plan,
    output logic       o_take,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_kind,
    output logic [7:0] o_value,
    output logic       o_last
);

    t_slot            r_slot;
    t_slot            n_slot;
    logic [GAP_W-1:0] r_cnt;
    logic [GAP_W-1:0] n_cnt;
    logic             r_out_vld;
    logic             r_kind;
    logic [7:0]       r_value;
    logic             r_last;
    logic             n_kind;
    logic [7:0]       n_value;
    logic             n_last;
    logic [3:0]       pres;
    logic             found;
    t_slot            nxt;
    logic             rep_more;
    logic             load;

    assign load = i_plan_vld && (!r_out_vld || !i_stall);

    always_comb begin
        pres[0] = 1'b1;
        pres[1] = (i_plan.d0 != DLY_NONE);
        pres[2] = i_plan.c1_en;
        pres[3] = i_plan.c1_en && (i_plan.d1 != DLY_NONE);

        found = 1'b0;
        nxt   = SL_C0;
        for (int q = 0; q < 4; q++) begin
            if (!found && q > int'(r_slot) && pres[q]) begin
                found = 1'b1;
                nxt   = t_slot'(2'(q));
            end
        end

        rep_more = (r_slot == SL_C0) && ((r_cnt + GAP_W'(1)) != i_plan.cnt);

        unique case (r_slot)
            SL_C0: begin
                n_kind  = 1'b0;
                n_value = i_plan.c0;
            end
            SL_D0: begin
                n_kind  = 1'b1;
                n_value = {1'b0, i_plan.d0};
            end
            SL_C1: begin
                n_kind  = 1'b0;
                n_value = CH_LF;
            end
            SL_D1: begin
                n_kind  = 1'b1;
                n_value = {1'b0, i_plan.d1};
            end
        endcase

        n_last = !rep_more && !found;

        if (rep_more) begin
            n_slot = SL_C0;
            n_cnt  = r_cnt + GAP_W'(1);
        end else if (found) begin
            n_slot = nxt;
            n_cnt  = '0;
        end else begin
            n_slot = SL_C0;
            n_cnt  = '0;
        end
    end

    assign o_take = load && n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot    <= SL_C0;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (load) begin
                r_slot    <= n_slot;
                r_cnt     <= n_cnt;
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind  <= n_kind;
            r_value <= n_value;
            r_last  <= n_last;
        end
    end

    assign o_valid = r_out_vld;
    assign o_kind  = r_kind;
    assign o_value = r_value;
    assign o_last  = r_last;

    `TTO_ASSERT_IMP(a_cnt_in_range, i_plan_vld, r_cnt < i_plan.cnt, "repeat count overran")
    `TTO_ASSERT_IMP(a_cnt_slot0, r_cnt != '0, r_slot == SL_C0, "repeat outside first slot")
    `TTO_ASSERT_IMP(a_slot_needs_plan, r_slot != SL_C0, i_plan_vld, "slot set with no item")
    `TTO_ASSERT_NXT(a_take_rewinds, o_take, r_slot == SL_C0 && r_cnt == '0 && o_last,
                    "item released without rewind")

endmodule

FILE: rtl/tty_output_converter.sv
`timescale 1ns / 1ps
// Terminal output converter.
// Input channel: i_valid / o_stall with i_char_in; an item is taken at a rising
// edge with i_valid high and o_stall low. Output channel: o_valid / i_stall
// with o_kind (0 character, 1 fill delay), o_value and o_last; o_last marks
// the final result of each input item.
// Configuration: write i_cfg_data to register i_cfg_idx while i_cfg_we is
// high; write only while idle. Unknown indexes are ignored.
// Path: taking an item loads its plan into the plan register; the first result
// is then loaded from it into the output register, where it can be accepted.
// Throughput: one result per cycle from the output sequencer unless stalled, so
// an item that makes one result sustains one item per cycle; an item with n
// results (up to TAB_STOP for an expanded tab) holds the sequencer until done.
// Reset: configuration returns to its defaults (CR mode on, all else off), the
// column goes to zero and both stages empty.
// Stall: a stalled result holds in the output register; the next result waits
// in the plan register, and o_stall rises once that register cannot drain.

module tty_output_converter
    import tto_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [1:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_in,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_kind,
    output logic [7:0] o_value,
    output logic       o_last
);

    t_cfg  r_cfg;
    t_plan plan;
    logic  plan_vld;
    logic  take;

    // Configuration registers: decode the index, hold until rewritten.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.raw_mode   <= 1'b0;
            r_cfg.cr_mode    <= 1'b1;
            r_cfg.nl_delay   <= 2'd0;
            r_cfg.tab_delay  <= 2'd0;
            r_cfg.cr_delay   <= 2'd0;
            r_cfg.vert_delay <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RAW_MODE:   r_cfg.raw_mode   <= i_cfg_data[0];
                REG_CR_MODE:    r_cfg.cr_mode    <= i_cfg_data[0];
                REG_NL_DELAY:   r_cfg.nl_delay   <= i_cfg_data;
                REG_TAB_DELAY:  r_cfg.tab_delay  <= i_cfg_data;
                REG_CR_DELAY:   r_cfg.cr_delay   <= i_cfg_data;
                REG_VERT_DELAY: r_cfg.vert_delay <= i_cfg_data[0];
                default: ; // drop writes beyond the register list
            endcase
        end
    end

    // Front stage: classify the character, advance the column, store the plan.
    tto_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_char_in  (i_char_in),
        .o_plan_vld (plan_vld),
        .o_plan     (plan),
        .i_take     (take)
    );

    // Back stage: walk the plan, one result into the output register a cycle while not stalled.
    tto_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_plan_vld (plan_vld),
        .i_plan     (plan),
        .o_take     (take),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_kind     (o_kind),
        .o_value    (o_value),
        .o_last     (o_last)
    );

endmodule
